// ===== rtl/core/gmw_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid map warp and merge package
// Shared payload types, register indexes, opcodes and arithmetic widths.
// ----------------------------------------------------------------------------
package gmw_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TRIG_W     = 16;
  localparam int SHIFT_W    = 10;

  localparam int Q_FRAC = 15;
  localparam int UW     = 19;
  localparam int PW     = UW + TRIG_W;
  localparam int NW     = PW + 3;
  localparam int DW     = 24;

  localparam logic signed [NW-1:0] TRUNC_BIAS = NW'((1 << Q_FRAC) - 1);

  localparam logic [1:0] OP_SCATTER = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WARP_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_THETA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_THETA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_VALUE = 3'd7;

  localparam logic [PIX_W-1:0]         UNKNOWN_RESET = 8'd205;
  localparam logic signed [TRIG_W-1:0] COS_RESET     = 16'sd16384;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [PIX_W-1:0]   source_pixel;
    logic [PIX_W-1:0]   base_pixel;
  } gmw_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] merged_pixel;
    logic             from_warped;
  } gmw_out_t;

endpackage

// ===== rtl/core/grid_map_warp_and_merge_unit.sv =====
// ----------------------------------------------------------------------------
// Grid map warp and merge unit
// Forward-maps occupancy grid pixels into a frame store by shift or rotation
// and merges the store with a base map on read.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                   Payload
//   cfg       in         cfg_we_i (no wait)          cfg_index_i, cfg_wdata_i
//   in        in         in_valid_i / in_ready_o     in_data_i (gmw_in_t)
//   out       out        out_valid_o / out_ready_i   out_data_o (gmw_out_t)
//
// One item is in work at a time. A translate scatter passes through the write state, a rotate
// scatter through the multiply, sum, truncate and write stages, and a skipped scatter or an
// unused opcode is done in the idle state. A read passes the address and data states and waits
// there for the output register to drain. A clear sweeps every entry, writing one entry per cycle.
// After reset a sweep fills the store with 205 before the first input transfer is taken.
// A pending result does not stop scatters or clears.
// ----------------------------------------------------------------------------
module grid_map_warp_and_merge_unit #(
  parameter int FRAME_ROWS = 512,
  parameter int FRAME_COLS = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gmw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gmw_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  gmw_pkg::gmw_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output gmw_pkg::gmw_out_t                out_data_o
);

  localparam int DEPTH = FRAME_ROWS * FRAME_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = gmw_pkg::DW;
  localparam int UW    = gmw_pkg::UW;
  localparam int PW    = gmw_pkg::PW;
  localparam int NW    = gmw_pkg::NW;
  localparam int PIX_W = gmw_pkg::PIX_W;

  localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]        COLS_A    = AW'(FRAME_COLS);
  localparam logic signed [DW-1:0] ROWS_S    = DW'(FRAME_ROWS);
  localparam logic signed [DW-1:0] COLS_S    = DW'(FRAME_COLS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_RADDR = 3'd6;
  localparam logic [2:0] S_RDATA = 3'd7;

  logic                                mode_q;
  logic signed [gmw_pkg::TRIG_W-1:0]   cos_q, sin_q, cx_q, cy_q;
  logic signed [gmw_pkg::SHIFT_W-1:0]  shx_q, shy_q;
  logic [PIX_W-1:0]                    unk_q;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [PIX_W-1:0]  fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  gmw_pkg::gmw_out_t out_data_q, out_data_d;
  logic              out_load;

  logic [gmw_pkg::COORD_W-1:0] item_row_q, item_col_q;
  logic [PIX_W-1:0]            src_q, base_q;
  logic                        rd_inside_q;
  logic signed [UW-1:0]        u_q, w_q, u_d, w_d;
  logic signed [PW-1:0]        p_uc_q, p_ws_q, p_us_q, p_wc_q;
  logic signed [NW-1:0]        ncol_q, nrow_q, ncol_d, nrow_d, ncol_adj, nrow_adj;
  logic signed [DW-1:0]        dest_row_q, dest_col_q, tr_row, tr_col;

  logic             in_fire;
  logic             src_inside;
  logic             dest_ok;
  logic             ram_en, ram_we;
  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cos_q  <= gmw_pkg::COS_RESET;
      sin_q  <= '0;
      cx_q   <= '0;
      cy_q   <= '0;
      shx_q  <= '0;
      shy_q  <= '0;
      unk_q  <= gmw_pkg::UNKNOWN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gmw_pkg::REG_WARP_MODE:     mode_q <= cfg_wdata_i[0];
        gmw_pkg::REG_COS_THETA:     cos_q  <= $signed(cfg_wdata_i);
        gmw_pkg::REG_SIN_THETA:     sin_q  <= $signed(cfg_wdata_i);
        gmw_pkg::REG_CENTER_X:      cx_q   <= $signed(cfg_wdata_i);
        gmw_pkg::REG_CENTER_Y:      cy_q   <= $signed(cfg_wdata_i);
        gmw_pkg::REG_SHIFT_X:       shx_q  <= $signed(cfg_wdata_i[gmw_pkg::SHIFT_W-1:0]);
        gmw_pkg::REG_SHIFT_Y:       shy_q  <= $signed(cfg_wdata_i[gmw_pkg::SHIFT_W-1:0]);
        gmw_pkg::REG_UNKNOWN_VALUE: unk_q  <= cfg_wdata_i[PIX_W-1:0];
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign src_inside = ($signed(DW'(in_data_i.pixel_row)) < ROWS_S) &&
                      ($signed(DW'(in_data_i.pixel_col)) < COLS_S);

  assign tr_row = $signed(DW'(in_data_i.pixel_row)) + DW'(shy_q);
  assign tr_col = $signed(DW'(in_data_i.pixel_col)) - DW'(shx_q);

  assign u_d = (($signed(UW'(in_data_i.pixel_col)) - UW'(cx_q)) <<< 1) + UW'(1);
  assign w_d = ((-UW'(cy_q) - $signed(UW'(in_data_i.pixel_row))) <<< 1) - UW'(1);

  assign ncol_d = NW'(p_uc_q) - NW'(p_ws_q) + (NW'(cx_q) <<< gmw_pkg::Q_FRAC);
  assign nrow_d = -(NW'(p_us_q) + NW'(p_wc_q)) - (NW'(cy_q) <<< gmw_pkg::Q_FRAC);

  assign ncol_adj = ncol_q + (ncol_q[NW-1] ? gmw_pkg::TRUNC_BIAS : NW'(0));
  assign nrow_adj = nrow_q + (nrow_q[NW-1] ? gmw_pkg::TRUNC_BIAS : NW'(0));

  assign dest_ok = !dest_row_q[DW-1] && (dest_row_q < ROWS_S) &&
                   !dest_col_q[DW-1] && (dest_col_q < COLS_S);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = addr_q;
    ram_wdata   = fill_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (addr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.opcode)
            gmw_pkg::OP_CLEAR: begin
              fill_d  = unk_q;
              addr_d  = '0;
              state_d = S_CLEAR;
            end
            gmw_pkg::OP_SCATTER: begin
              if (src_inside && (in_data_i.source_pixel != unk_q)) begin
                state_d = mode_q ? S_MUL : S_WRITE;
              end
            end
            gmw_pkg::OP_READ: state_d = S_RADDR;
            default: ;
          endcase
        end
      end
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_DIV;
      S_DIV: state_d = S_WRITE;
      S_WRITE: begin
        ram_en    = dest_ok;
        ram_we    = dest_ok;
        ram_addr  = AW'(dest_row_q) * COLS_A + AW'(dest_col_q);
        ram_wdata = src_q;
        state_d   = S_IDLE;
      end
      S_RADDR: begin
        ram_en   = rd_inside_q;
        ram_addr = AW'(item_row_q) * COLS_A + AW'(item_col_q);
        state_d  = S_RDATA;
      end
      S_RDATA: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (base_q != unk_q) begin
      out_data_d.merged_pixel = base_q;
      out_data_d.from_warped  = 1'b0;
    end else begin
      out_data_d.merged_pixel = rd_inside_q ? ram_rdata : unk_q;
      out_data_d.from_warped  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      fill_q      <= gmw_pkg::UNKNOWN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_row_q  <= in_data_i.pixel_row;
      item_col_q  <= in_data_i.pixel_col;
      src_q       <= in_data_i.source_pixel;
      base_q      <= in_data_i.base_pixel;
      rd_inside_q <= src_inside;
      u_q         <= u_d;
      w_q         <= w_d;
      dest_row_q  <= tr_row;
      dest_col_q  <= tr_col;
    end else if (state_q == S_DIV) begin
      dest_row_q <= DW'(nrow_adj >>> gmw_pkg::Q_FRAC);
      dest_col_q <= DW'(ncol_adj >>> gmw_pkg::Q_FRAC);
    end
    if (state_q == S_MUL) begin
      p_uc_q <= u_q * cos_q;
      p_ws_q <= w_q * sin_q;
      p_us_q <= u_q * sin_q;
      p_wc_q <= w_q * cos_q;
    end
    if (state_q == S_SUM) begin
      ncol_q <= ncol_d;
      nrow_q <= nrow_d;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  gmw_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_clear_starts_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.opcode == gmw_pkg::OP_CLEAR)
      |=> (state_q == S_CLEAR) && (addr_q == '0) && (fill_q == $past(unk_q)))
    else $error("Clear transfer did not start a sweep from the first entry.");

  a_sweep_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) && (addr_q != LAST_ADDR) |=> addr_q == $past(addr_q) + 1'b1)
    else $error("Clear sweep skipped or repeated an entry.");

  a_unknown_skipped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.opcode == gmw_pkg::OP_SCATTER) &&
      (in_data_i.source_pixel == unk_q) |=> state_q == S_IDLE)
    else $error("Unknown source pixel entered the scatter path.");

  a_read_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDATA) && (!out_valid_q || out_ready_i)
      |=> out_valid_o && (state_q == S_IDLE))
    else $error("Read result was not loaded into the output register.");

endmodule

// ===== rtl/core/gmw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module gmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/gmw_merge_checker.sv =====
// ----------------------------------------------------------------------------
// Grid map merge checker
// Follows register writes and input transfers to keep its own copy of the
// warped frame, predicts the merged pixel of every read and compares each
// output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gmw_merge_checker
  import gmw_pkg::*;
#(
  parameter int FRAME_ROWS = 512,
  parameter int FRAME_COLS = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  gmw_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  gmw_out_t              out_data_i,
  output int                    mismatch_count_o,
  output int                    pending_merges_o
);

  localparam longint HALF_PIXEL_SCALE = 32768;

  logic [PIX_W-1:0]          warped_cells [FRAME_ROWS*FRAME_COLS];
  logic                      rotate_mode;
  logic signed [TRIG_W-1:0]  cos_q;
  logic signed [TRIG_W-1:0]  sin_q;
  logic signed [15:0]        ctr_x;
  logic signed [15:0]        ctr_y;
  logic signed [SHIFT_W-1:0] shift_col;
  logic signed [SHIFT_W-1:0] shift_row;
  logic [PIX_W-1:0]          unknown_code;
  gmw_out_t                  merge_expect_q [$];
  int                        mismatches;

  function automatic void fill_frame(input logic [PIX_W-1:0] code);
    foreach (warped_cells[k]) warped_cells[k] = code;
  endfunction

  function automatic void report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: mismatch, %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_proc
    gmw_out_t want;
    gmw_out_t got;
    longint   row;
    longint   col;
    longint   u;
    longint   w;
    longint   dst_row;
    longint   dst_col;
    if (!rst_ni) begin
      fill_frame(UNKNOWN_RESET);
      rotate_mode  = 1'b0;
      cos_q        = COS_RESET;
      sin_q        = '0;
      ctr_x        = '0;
      ctr_y        = '0;
      shift_col    = '0;
      shift_row    = '0;
      unknown_code = UNKNOWN_RESET;
      merge_expect_q.delete();
      mismatches   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (merge_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result merged_pixel %0d from_warped %0d",
                                    got.merged_pixel, got.from_warped));
        end else begin
          want = merge_expect_q.pop_front();
          if (got.merged_pixel !== want.merged_pixel) begin
            report_mismatch($sformatf("merged_pixel expected %0d actual %0d",
                                      want.merged_pixel, got.merged_pixel));
          end
          if (got.from_warped !== want.from_warped) begin
            report_mismatch($sformatf("from_warped expected %0d actual %0d",
                                      want.from_warped, got.from_warped));
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        row = longint'(in_data_i.pixel_row);
        col = longint'(in_data_i.pixel_col);
        case (in_data_i.opcode)
          OP_SCATTER: begin
            if (row < FRAME_ROWS && col < FRAME_COLS &&
                in_data_i.source_pixel != unknown_code) begin
              if (!rotate_mode) begin
                dst_row = row + longint'(shift_row);
                dst_col = col - longint'(shift_col);
              end else begin
                // Rotation works in half-pixel units about the center cell.
                u = 2 * (col - longint'(ctr_x)) + 1;
                w = 2 * (-longint'(ctr_y) - row) - 1;
                dst_col = (u * longint'(cos_q) - w * longint'(sin_q)
                           + longint'(ctr_x) * HALF_PIXEL_SCALE) / HALF_PIXEL_SCALE;
                dst_row = (-(u * longint'(sin_q) + w * longint'(cos_q))
                           - longint'(ctr_y) * HALF_PIXEL_SCALE) / HALF_PIXEL_SCALE;
              end
              if (dst_row >= 0 && dst_row < FRAME_ROWS &&
                  dst_col >= 0 && dst_col < FRAME_COLS) begin
                warped_cells[dst_row * FRAME_COLS + dst_col] = in_data_i.source_pixel;
              end
            end
          end
          OP_READ: begin
            if (in_data_i.base_pixel != unknown_code) begin
              want.merged_pixel = in_data_i.base_pixel;
              want.from_warped  = 1'b0;
            end else begin
              want.merged_pixel = unknown_code;
              if (row < FRAME_ROWS && col < FRAME_COLS) begin
                want.merged_pixel = warped_cells[row * FRAME_COLS + col];
              end
              want.from_warped = 1'b1;
            end
            merge_expect_q.push_back(want);
          end
          OP_CLEAR: fill_frame(unknown_code);
          default: ;
        endcase
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WARP_MODE:     rotate_mode  = cfg_wdata_i[0];
          REG_COS_THETA:     cos_q        = cfg_wdata_i;
          REG_SIN_THETA:     sin_q        = cfg_wdata_i;
          REG_CENTER_X:      ctr_x        = cfg_wdata_i;
          REG_CENTER_Y:      ctr_y        = cfg_wdata_i;
          REG_SHIFT_X:       shift_col    = cfg_wdata_i[SHIFT_W-1:0];
          REG_SHIFT_Y:       shift_row    = cfg_wdata_i[SHIFT_W-1:0];
          REG_UNKNOWN_VALUE: unknown_code = cfg_wdata_i[PIX_W-1:0];
          default: ;
        endcase
      end
    end
    pending_merges_o = merge_expect_q.size();
    mismatch_count_o = mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Grid map warp and merge unit testbench
// Drives a directed sequence and then random phases of scatters, reads, unused opcodes and
// one clear, each phase under new register settings, with bursty input and a stalling
// output; a checker beside the block predicts and compares every read.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import gmw_pkg::*;

  localparam int         FRAME_ROWS    = 512;
  localparam int         FRAME_COLS    = 512;
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         RANDOM_PHASES = 11;
  localparam int         PHASE_ITEMS   = 150;
  localparam int         SETTLE_CYCLES = 16;
  localparam longint     CYCLE_LIMIT   = 4_000_000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  gmw_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  gmw_out_t              out_data_o;

  int         merge_mismatches;
  int         merges_pending;
  longint     cycle_count   = 0;
  logic [7:0] cur_unknown   = UNKNOWN_RESET;
  int         ready_left    = 0;
  int         ready_style   = 0;
  logic [31:0] stall_pattern = '0;

  grid_map_warp_and_merge_unit #(
    .FRAME_ROWS(FRAME_ROWS),
    .FRAME_COLS(FRAME_COLS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  gmw_merge_checker #(
    .FRAME_ROWS(FRAME_ROWS),
    .FRAME_COLS(FRAME_COLS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .mismatch_count_o(merge_mismatches),
    .pending_merges_o(merges_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL grid_map_warp_and_merge_unit");
      $finish;
    end
  end

  // The output side switches between steady, patterned, random and mostly
  // stalled acceptance for stretches of random length.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_style   = $urandom_range(0, 3);
      stall_pattern = $urandom;
      ready_left    = $urandom_range(64, 400);
    end
    ready_left--;
    case (ready_style)
      0:       out_ready_i = 1'b1;
      1:       out_ready_i = stall_pattern[ready_left % 32];
      2:       out_ready_i = $urandom_range(0, 1);
      default: out_ready_i = ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    if (idx == REG_UNKNOWN_VALUE) cur_unknown = data[7:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_item(input logic [1:0] op, input int row, input int col,
                           input int src, input int base);
    @(negedge clk_i);
    in_valid_i              = 1'b1;
    in_data_i.opcode        = op;
    in_data_i.pixel_row     = COORD_W'(row);
    in_data_i.pixel_col     = COORD_W'(col);
    in_data_i.source_pixel  = PIX_W'(src);
    in_data_i.base_pixel    = PIX_W'(base);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_input(1);
    while (merges_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int          win_row;
    int          win_col;
    int          r_lo;
    int          r_hi;
    int          c_lo;
    int          c_hi;
    int          burst_left;
    int          pick;
    int          row;
    int          col;
    logic [1:0]  op;
    logic        mode_v;
    logic [15:0] cos_v;
    logic [15:0] sin_v;
    logic [15:0] cx_v;
    logic [15:0] cy_v;
    logic [15:0] sx_v;
    logic [15:0] sy_v;
    logic [15:0] unk_v;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: reads of fresh and written corners, a skipped unknown
    // pixel and the unused opcode.
    send_item(OP_READ, 0, 0, 0, 205);
    send_item(OP_READ, 511, 511, 255, 0);
    send_item(OP_SCATTER, 0, 0, 255, 0);
    send_item(OP_SCATTER, 511, 511, 0, 255);
    send_item(OP_SCATTER, 5, 5, 205, 0);
    send_item(OP_UNUSED, 511, 511, 255, 255);
    send_item(OP_READ, 0, 0, 0, 205);
    send_item(OP_READ, 511, 511, 0, 205);
    send_item(OP_READ, 5, 5, 0, 205);
    drain_results();

    // Extreme shifts: one target lands in the corner, the others leave the frame.
    write_reg(REG_SHIFT_X, 16'(-511));
    write_reg(REG_SHIFT_Y, 16'(-511));
    send_item(OP_SCATTER, 511, 0, 77, 0);
    send_item(OP_SCATTER, 0, 0, 1, 0);
    send_item(OP_SCATTER, 511, 1, 2, 0);
    send_item(OP_READ, 0, 511, 0, 205);
    drain_results();

    write_reg(REG_UNKNOWN_VALUE, 16'd0);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_READ, 0, 511, 0, 0);
    send_item(OP_READ, 0, 0, 0, 255);
    drain_results();

    // Quarter turn about the frame middle; the clear fill must survive the
    // change of the unknown code.
    write_reg(REG_UNKNOWN_VALUE, 16'd255);
    write_reg(REG_WARP_MODE, 16'd1);
    write_reg(REG_COS_THETA, 16'd0);
    write_reg(REG_SIN_THETA, 16'd16384);
    write_reg(REG_CENTER_X, 16'd256);
    write_reg(REG_CENTER_Y, 16'(-256));
    send_item(OP_READ, 3, 3, 0, 255);
    send_item(OP_SCATTER, 250, 260, 11, 0);
    send_item(OP_SCATTER, 256, 256, 12, 0);
    send_item(OP_READ, 255, 256, 0, 255);
    drain_results();

    // Half turn about the origin sends targets to negative coordinates.
    write_reg(REG_COS_THETA, 16'(-16384));
    write_reg(REG_SIN_THETA, 16'd0);
    write_reg(REG_CENTER_X, 16'd0);
    write_reg(REG_CENTER_Y, 16'd0);
    send_item(OP_SCATTER, 10, 10, 9, 0);
    send_item(OP_READ, 0, 0, 0, 255);
    drain_results();

    burst_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      win_row = $urandom_range(0, 511);
      win_col = $urandom_range(0, 511);
      r_lo    = (win_row < 8) ? 0 : win_row - 8;
      r_hi    = (win_row > 503) ? 511 : win_row + 7;
      c_lo    = (win_col < 8) ? 0 : win_col - 8;
      c_hi    = (win_col > 503) ? 511 : win_col + 7;

      mode_v = (ph % 2 == 1) || (ph >= 7);
      cos_v  = 16'($urandom);
      sin_v  = 16'($urandom);
      case (ph)
        1:  begin cos_v = 16'd11585;   sin_v = 16'd11585;   end
        3:  begin cos_v = 16'(-15137); sin_v = 16'd6270;    end
        5:  begin cos_v = 16'd16384;   sin_v = 16'd0;       end
        7:  begin cos_v = 16'h8000;    sin_v = 16'h7fff;    end
        8:  begin cos_v = 16'd0;       sin_v = 16'(-16384); end
        9:  begin cos_v = 16'd6270;    sin_v = 16'(-15137); end
        default: ;
      endcase
      // The rotation pivots on column center_x and row minus center_y.
      cx_v = 16'(win_col);
      cy_v = 16'(-win_row);
      if (ph == 9) begin
        cx_v = 16'h8000;
        cy_v = 16'h7fff;
      end
      sx_v = 16'($urandom_range(0, 16) - 8);
      sy_v = 16'($urandom_range(0, 16) - 8);
      if (ph == 4) begin
        sx_v = 16'h0200;
        sy_v = 16'd511;
      end else if (ph == 6) begin
        sx_v = 16'd511;
        sy_v = 16'(-511);
      end
      unk_v = 16'($urandom_range(0, 255));
      if (ph == 2) unk_v = 16'd0;
      if (ph == 6) unk_v = 16'd255;
      if (ph == 8) unk_v = 16'd205;

      write_reg(REG_WARP_MODE, {15'd0, mode_v});
      write_reg(REG_COS_THETA, cos_v);
      write_reg(REG_SIN_THETA, sin_v);
      write_reg(REG_CENTER_X, cx_v);
      write_reg(REG_CENTER_Y, cy_v);
      write_reg(REG_SHIFT_X, sx_v);
      write_reg(REG_SHIFT_Y, sy_v);
      write_reg(REG_UNKNOWN_VALUE, unk_v);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (k == PHASE_ITEMS - 1) op = OP_READ;
        else if (ph == 5 && k == PHASE_ITEMS / 2) op = OP_CLEAR;
        else if (pick < 45) op = OP_SCATTER;
        else if (pick < 95) op = OP_READ;
        else op = OP_UNUSED;
        if ($urandom_range(0, 6) == 0) begin
          row = $urandom_range(0, 511);
          col = $urandom_range(0, 511);
        end else begin
          row = $urandom_range(r_lo, r_hi);
          col = $urandom_range(c_lo, c_hi);
        end
        send_item(op, row, col,
                  ($urandom_range(0, 6) == 0) ? int'(cur_unknown) : $urandom_range(0, 255),
                  ($urandom_range(0, 9) < 6) ? int'(cur_unknown) : $urandom_range(0, 255));
      end
      drain_results();
    end

    if (merge_mismatches == 0 && merges_pending == 0) begin
      $display("PASS grid_map_warp_and_merge_unit");
    end else begin
      $display("FAIL grid_map_warp_and_merge_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gmw_pkg.sv
rtl/core/gmw_ram.sv
rtl/core/grid_map_warp_and_merge_unit.sv
tb/gmw_merge_checker.sv
tb/tb_top.sv
